>>> rtl/asfdo_pkg.sv
// Shared definitions for the drop-oldest audio sample FIFO.
// Holds the default depth, the capacity reset value, the mode codes and the
// store control struct. No dependencies.
`default_nettype none

package asfdo_pkg;

  localparam int unsigned DefaultDepth  = 4096;
  localparam int unsigned CapacityReset = 4096;
  localparam int unsigned FieldCountW   = 13;
  localparam int unsigned SampleW       = 16;

  typedef enum logic [1:0] {
    ModeWrite    = 2'd0,
    ModeRead     = 2'd1,
    ModeTruncate = 2'd2
  } mode_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/audio_sample_fifo_drop_oldest_top.sv
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle if no output stall holds it; the circular
// pointers and count update on accept; the store registers read data.
// Reset clears the pointers, the fill count, the countdown and the output
// valid, and loads the capacity with its reset value clamped to DEPTH.
// Top level of the drop-oldest audio FIFO; uses asfdo_pkg and asfdo_store.
`default_nettype none

module audio_sample_fifo_drop_oldest_top #(
  parameter int unsigned DEPTH = asfdo_pkg::DefaultDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_data_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic signed [15:0] sample_in_i,
  input  wire logic        silent_i,
  input  wire logic [12:0] keep_count_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [15:0] sample_out_o,
  output logic             read_valid_o,
  output logic             dropped_oldest_o,
  output logic [12:0]      fill_count_o,
  output logic [12:0]      not_silent_count_o,
  output logic signed [15:0] newest_sample_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned FW = asfdo_pkg::FieldCountW;
  localparam int unsigned KW = (CW > FW) ? CW : FW;
  localparam int unsigned SW = CW + 1;
  localparam logic [CW-1:0] CapReset =
    CW'((asfdo_pkg::CapacityReset > DEPTH) ? DEPTH : asfdo_pkg::CapacityReset);

  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] held_q, held_d;
  logic [CW-1:0] cd_q, cd_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [15:0]   newest_q, newest_d;

  logic          out_valid_q, out_valid_d;
  logic          rd_valid_q;
  logic          dropped_q;
  logic [12:0]   fill_q;
  logic [12:0]   cd_out_q;
  logic [15:0]   newest_out_q;

  logic          accept;
  logic [CW-1:0] n_rm;
  logic          is_write;
  logic          is_read;
  logic          dropped;
  logic [KW-1:0] held_ext;
  logic [KW-1:0] keep_ext;
  logic [SW-1:0] head_sum;
  logic [SW-1:0] head_wrap;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_wrap;
  logic [AW-1:0] tail_idx;
  asfdo_pkg::store_ctrl_t store_ctrl;
  logic [15:0]   rd_data;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign held_ext = KW'(held_q);
  assign keep_ext = KW'(keep_count_i);

  // Work out how many oldest samples this item removes.
  always_comb begin
    n_rm     = '0;
    is_write = 1'b0;
    is_read  = 1'b0;
    dropped  = 1'b0;
    unique case (mode_i)
      asfdo_pkg::ModeWrite: begin
        is_write = 1'b1;
        if (held_q >= cap_q) begin
          n_rm    = held_q - cap_q + CW'(1);
          dropped = 1'b1;
        end
      end
      asfdo_pkg::ModeRead: begin
        if (held_q != '0) begin
          n_rm    = CW'(1);
          is_read = 1'b1;
        end
      end
      asfdo_pkg::ModeTruncate: begin
        if (held_ext > keep_ext) begin
          n_rm = CW'(held_ext - keep_ext);
        end
      end
      default: begin
      end
    endcase
  end

  // Circular index arithmetic; both sums stay below twice the depth.
  assign head_sum  = SW'(oldest_q) + SW'(n_rm);
  assign head_wrap = (head_sum >= SW'(DEPTH)) ? head_sum - SW'(DEPTH) : head_sum;
  // The write slot is oldest + held, unchanged by removing from the head.
  assign tail_sum  = SW'(oldest_q) + SW'(held_q);
  assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
  assign tail_idx  = tail_wrap[AW-1:0];

  always_comb begin
    oldest_d = oldest_q;
    held_d   = held_q;
    cd_d     = cd_q;
    cap_d    = cap_q;
    newest_d = newest_q;
    priority if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        cap_d = CW'(1);
      end else if (KW'(cfg_data_i) > KW'(DEPTH)) begin
        cap_d = CW'(DEPTH);
      end else begin
        cap_d = CW'(cfg_data_i);
      end
      oldest_d = '0;
      held_d   = '0;
      cd_d     = '0;
    end else if (accept) begin
      oldest_d = head_wrap[AW-1:0];
      held_d   = held_q - n_rm + CW'(is_write);
      if (is_write && !silent_i) begin
        cd_d = cap_q;
      end else begin
        cd_d = (cd_q > n_rm) ? cd_q - n_rm : '0;
      end
      if (is_write) begin
        newest_d = sample_in_i;
      end
    end
  end

  assign store_ctrl.wr_en = accept & is_write;
  assign store_ctrl.rd_en = accept & is_read;

  asfdo_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .ctrl_i    (store_ctrl),
    .wr_addr_i (tail_idx),
    .wr_data_i (sample_in_i),
    .rd_addr_i (oldest_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      held_q      <= '0;
      cd_q        <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      oldest_q    <= oldest_d;
      held_q      <= held_d;
      cd_q        <= cd_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Result register: load on every transfer in, hold otherwise.
  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
    if (accept) begin
      rd_valid_q   <= is_read;
      dropped_q    <= dropped;
      fill_q       <= FW'(held_d);
      cd_out_q     <= FW'(cd_d);
      newest_out_q <= (held_d != '0) ? newest_d : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sample_out_o       = rd_valid_q ? rd_data : '0;
  assign read_valid_o       = rd_valid_q;
  assign dropped_oldest_o   = dropped_q;
  assign fill_count_o       = fill_q;
  assign not_silent_count_o = cd_out_q;
  assign newest_sample_o    = newest_out_q;

  a_held_le_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cap_q)
    else $error("fill count above capacity");

  a_cd_le_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_q <= cap_q)
    else $error("countdown above capacity");

  a_oldest_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q < AW'(DEPTH - 1) || oldest_q == AW'(DEPTH - 1))
    else $error("oldest index out of range");

  a_read_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i && mode_i == asfdo_pkg::ModeRead && held_q != '0
    |=> read_valid_o && out_valid_o)
    else $error("read of a non-empty buffer not flagged");

endmodule

`default_nettype wire

>>> rtl/asfdo_store.sv
// Sample store of the drop-oldest FIFO: one write port, one read port with
// registered read data. Depends on asfdo_pkg for the control struct.
`default_nettype none

module asfdo_store #(
  parameter int unsigned DEPTH = asfdo_pkg::DefaultDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire asfdo_pkg::store_ctrl_t      ctrl_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [asfdo_pkg::SampleW-1:0] wr_data_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output logic      [asfdo_pkg::SampleW-1:0] rd_data_o
);

  logic [asfdo_pkg::SampleW-1:0] mem [DEPTH];
  logic [asfdo_pkg::SampleW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read, so it survives an output stall.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for the drop-oldest PCM sample FIFO: a scoreboard
// class predicts every result; plain tasks drive operations and the capacity.
// Depends on asfdo_pkg and audio_sample_fifo_drop_oldest_top.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Depth      = asfdo_pkg::DefaultDepth;
  localparam logic [1:0]  ModeUnused = 2'd3;
  localparam int unsigned LongHold   = 64;
  localparam int unsigned Limit      = 2000;
  localparam int unsigned MaxReports = 40;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] sample;
    logic               silent;
    logic [12:0]        keep;
  } pcm_op_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               read_valid;
    logic               dropped_oldest;
    logic [12:0]        fill_count;
    logic [12:0]        not_silent_count;
    logic signed [15:0] newest_sample;
  } fifo_status_t;

  class pcm_fifo_scoreboard;
    logic signed [15:0] sample_mem [Depth];
    int unsigned        head;
    int unsigned        held;
    int unsigned        countdown;
    int unsigned        cap;
    fifo_status_t       pending_results [$];
    int unsigned        errors;

    function new();
      errors = 0;
      load_capacity(asfdo_pkg::CapacityReset);
    endfunction

    function void load_capacity(int unsigned value);
      cap       = (value == 0) ? 1 : (value > Depth) ? Depth : value;
      head      = 0;
      held      = 0;
      countdown = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Drop the n oldest samples; the countdown saturates at zero.
    function void drop_oldest(int unsigned n);
      if (n > held) n = held;
      head      = (head + n) % Depth;
      held      = held - n;
      countdown = (countdown > n) ? countdown - n : 0;
    endfunction

    function void note_input_transfer(pcm_op_t op);
      fifo_status_t want;
      want = '0;
      case (op.mode)
        asfdo_pkg::ModeWrite: begin
          if (held >= cap) begin
            drop_oldest(held - cap + 1);
            want.dropped_oldest = 1'b1;
          end
          sample_mem[(head + held) % Depth] = op.sample;
          held++;
          if (!op.silent) countdown = cap;
        end
        asfdo_pkg::ModeRead: begin
          if (held != 0) begin
            want.sample_out = sample_mem[head];
            want.read_valid = 1'b1;
            drop_oldest(1);
          end
        end
        asfdo_pkg::ModeTruncate: begin
          if (held > op.keep) drop_oldest(held - op.keep);
        end
        default: ;
      endcase
      want.fill_count       = held[12:0];
      want.not_silent_count = countdown[12:0];
      if (held != 0) want.newest_sample = sample_mem[(head + held - 1) % Depth];
      pending_results.push_back(want);
    endfunction

    function bit field_ok(string name, logic signed [31:0] want_v, logic signed [31:0] got_v);
      if (got_v === want_v) return 1'b1;
      if (errors < MaxReports)
        $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      return 1'b0;
    endfunction

    function void check_output_transfer(fifo_status_t got);
      fifo_status_t want;
      bit           good;
      if (pending_results.size() == 0) begin
        if (errors < MaxReports)
          $display("%0t: result transfer with nothing expected, expected none, got fill %0d",
                   $time, got.fill_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      good = field_ok("sample_out", $signed(want.sample_out), $signed(got.sample_out));
      good &= field_ok("read_valid", want.read_valid, got.read_valid);
      good &= field_ok("dropped_oldest", want.dropped_oldest, got.dropped_oldest);
      good &= field_ok("fill_count", want.fill_count, got.fill_count);
      good &= field_ok("not_silent_count", want.not_silent_count, got.not_silent_count);
      good &= field_ok("newest_sample", $signed(want.newest_sample),
                       $signed(got.newest_sample));
      if (!good) errors++;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [12:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         mode_i;
  logic signed [15:0] sample_in_i;
  logic               silent_i;
  logic [12:0]        keep_count_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] sample_out_o;
  logic               read_valid_o;
  logic               dropped_oldest_o;
  logic [12:0]        fill_count_o;
  logic [12:0]        not_silent_count_o;
  logic signed [15:0] newest_sample_o;

  pcm_fifo_scoreboard scoreboard;
  bit                 quiet_tail    = 1'b0;
  bit                 steady_sender = 1'b0;
  bit                 long_hold_req = 1'b0;
  int unsigned        idle_cycles   = 0;

  audio_sample_fifo_drop_oldest_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .sample_in_i        (sample_in_i),
    .silent_i           (silent_i),
    .keep_count_i       (keep_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sample_out_o       (sample_out_o),
    .read_valid_o       (read_valid_o),
    .dropped_oldest_o   (dropped_oldest_o),
    .fill_count_o       (fill_count_o),
    .not_silent_count_o (not_silent_count_o),
    .newest_sample_o    (newest_sample_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample both channels at the edge; values are the ones driven before it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        scoreboard.check_output_transfer(fifo_status_t'{sample_out_o, read_valid_o,
            dropped_oldest_o, fill_count_o, not_silent_count_o, newest_sample_o});
      if (in_valid_i && !in_stall_o)
        scoreboard.note_input_transfer(pcm_op_t'{mode_i, sample_in_i, silent_i,
                                                 keep_count_i});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == Limit) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin : receiver_stall
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left  = 0;
    calm_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) stall_left--;
      if (calm_left != 0) calm_left--;
      else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(20, 100);
      if (stall_left == 0) begin
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          stall_left    = LongHold;
        end else if (!quiet_tail && calm_left == 0 && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 7);
        end
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  task automatic send_op(input logic [1:0] op, input logic signed [15:0] pcm,
                         input logic silent, input logic [12:0] keep);
    int unsigned gap;
    if (!quiet_tail && !steady_sender && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= op;
    sample_in_i  <= pcm;
    silent_i     <= silent;
    keep_count_i <= keep;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Mostly keep counts near the capacity so truncates actually bite.
  task automatic send_random_op(input int unsigned keep_span, input int unsigned write_pct);
    int unsigned roll;
    logic [1:0]  op;
    logic [12:0] keep;
    roll = $urandom_range(0, 11);
    if ($urandom_range(0, 99) < write_pct) op = asfdo_pkg::ModeWrite;
    else if (roll < 7) op = asfdo_pkg::ModeRead;
    else if (roll < 11) op = asfdo_pkg::ModeTruncate;
    else op = ModeUnused;
    if ($urandom_range(0, 4) == 0) keep = 13'($urandom);
    else keep = 13'($urandom_range(0, keep_span + 2));
    send_op(op, 16'($urandom), 1'($urandom), keep);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (scoreboard.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [12:0] value);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scoreboard.load_capacity(value);
  endtask

  initial begin : stimulus
    logic [12:0] phase_caps [6];
    scoreboard   = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    mode_i       = asfdo_pkg::ModeWrite;
    sample_in_i  = '0;
    silent_i     = 1'b0;
    keep_count_i = '0;
    phase_caps   = '{13'd3, 13'd1, 13'd16, 13'd2, 13'd64, 13'd7};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: empty reads and truncates, unused mode, extreme samples.
    send_op(asfdo_pkg::ModeRead, 16'sd0, 1'b0, 13'd0);
    send_op(asfdo_pkg::ModeTruncate, 16'sd0, 1'b0, 13'd0);
    send_op(ModeUnused, 16'sh1234, 1'b0, 13'd5);
    send_op(asfdo_pkg::ModeWrite, 16'sd32767, 1'b0, 13'd0);
    send_op(asfdo_pkg::ModeWrite, -16'sd32768, 1'b1, 13'd0);
    send_op(asfdo_pkg::ModeWrite, 16'sd0, 1'b1, 13'd0);
    send_op(asfdo_pkg::ModeWrite, -16'sd1, 1'b0, 13'h1fff);
    send_op(ModeUnused, -16'sd1, 1'b1, 13'h1fff);
    send_op(asfdo_pkg::ModeTruncate, 16'sd0, 1'b0, 13'h1fff);
    send_op(asfdo_pkg::ModeTruncate, 16'sd0, 1'b0, 13'd4);
    send_op(asfdo_pkg::ModeRead, 16'sd0, 1'b0, 13'd0);
    send_op(asfdo_pkg::ModeTruncate, 16'sd0, 1'b0, 13'd1);
    send_op(asfdo_pkg::ModeRead, 16'sd0, 1'b0, 13'd0);
    send_op(asfdo_pkg::ModeRead, 16'sd0, 1'b0, 13'd0);

    // Capacity zero behaves as one: the second write drops the first.
    write_capacity(13'd0);
    send_op(asfdo_pkg::ModeWrite, 16'sd100, 1'b0, 13'd0);
    send_op(asfdo_pkg::ModeWrite, -16'sd100, 1'b1, 13'd0);
    send_op(asfdo_pkg::ModeRead, 16'sd0, 1'b0, 13'd0);
    send_op(asfdo_pkg::ModeRead, 16'sd0, 1'b0, 13'd0);

    for (int p = 0; p < 6; p++) begin
      write_capacity(phase_caps[p]);
      steady_sender = (p % 3 == 2);
      for (int n = 0; n < 125; n++)
        send_random_op(phase_caps[p], (phase_caps[p] > 8) ? 70 : 55);
    end

    // Back-pressure: hold the output while writes keep coming.
    write_capacity(13'd24);
    steady_sender = 1'b1;
    long_hold_req = 1'b1;
    for (int n = 0; n < 40; n++)
      send_op(asfdo_pkg::ModeWrite, 16'($urandom), 1'($urandom), 13'd0);
    steady_sender = 1'b0;

    // Above DEPTH clamps to the full store.
    write_capacity(13'h1fff);
    for (int n = 0; n < 100; n++)
      send_op(asfdo_pkg::ModeWrite, 16'($urandom), 1'($urandom), 13'($urandom));
    for (int n = 0; n < 50; n++) send_random_op(Depth, 40);

    quiet_tail = 1'b1;
    write_capacity(13'd10);
    for (int n = 0; n < 100; n++) send_random_op(10, 55);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
